[hw/rtl/ntc_pkg.sv]
package ntc_pkg;

  typedef enum logic [2:0] {
    TC_S8  = 3'd0,
    TC_U8  = 3'd1,
    TC_S16 = 3'd2,
    TC_U16 = 3'd3,
    TC_S32 = 3'd4,
    TC_U32 = 3'd5,
    TC_F32 = 3'd6,
    TC_F64 = 3'd7
  } type_code_t;

  localparam logic [1:0] REG_SRC_TYPE = 2'd0;
  localparam logic [1:0] REG_DST_TYPE = 2'd1;

  // Decoded word after the first stage.
  typedef struct packed {
    type_code_t         src;
    type_code_t         dst;
    logic               last;
    logic [63:0]        raw;
    logic signed [33:0] ival;
    logic               sgn;
    logic               is_nan;
    logic               is_inf;
    logic signed [12:0] exp;
    logic [63:0]        frac;
  } dec_t;

  // Normalized word after the second stage.
  typedef struct packed {
    type_code_t         src;
    type_code_t         dst;
    logic               last;
    logic [63:0]        raw;
    logic signed [33:0] ival;
    logic               sgn;
    logic               is_nan;
    logic               is_inf;
    logic               is_zero;
    logic signed [12:0] exp;
    logic [63:0]        frac;
  } norm_t;

  // Aligned word after the third stage.
  typedef struct packed {
    type_code_t         src;
    type_code_t         dst;
    logic               last;
    logic [63:0]        raw;
    logic signed [33:0] ival;
    logic               sgn;
    logic               is_nan;
    logic               is_inf;
    logic               is_zero;
    logic signed [12:0] sp_expb;
    logic [23:0]        sp_man;
    logic               sp_guard;
    logic               sp_sticky;
    logic [63:0]        dp_bits;
    logic               int_huge;
    logic [34:0]        int_t;
  } algn_t;

  function automatic logic pair_ok(input type_code_t d, input type_code_t s);
    logic [7:0] row;
    case (d)
      TC_S8:   row = 8'hC1;
      TC_U8:   row = 8'hCA;
      TC_S16:  row = 8'hCC;
      TC_U16:  row = 8'hCA;
      TC_S32:  row = 8'hD0;
      TC_U32:  row = 8'hF0;
      TC_F32:  row = 8'hDF;
      TC_F64:  row = 8'hDF;
      default: row = 8'h00;
    endcase
    return row[s];
  endfunction

  function automatic logic signed [35:0] int_lo(input type_code_t d);
    case (d)
      TC_S8:   return -36'sd128;
      TC_S16:  return -36'sd32768;
      TC_S32:  return -36'sd2147483648;
      default: return 36'sd0;
    endcase
  endfunction

  function automatic logic signed [35:0] int_hi(input type_code_t d);
    case (d)
      TC_S8:   return 36'sd127;
      TC_U8:   return 36'sd255;
      TC_S16:  return 36'sd32767;
      TC_U16:  return 36'sd65535;
      TC_S32:  return 36'sd2147483647;
      default: return 36'sd4294967295;
    endcase
  endfunction

  function automatic logic [63:0] width_mask(input type_code_t t);
    case (t)
      TC_S8, TC_U8:           return 64'h0000_0000_0000_00FF;
      TC_S16, TC_U16:         return 64'h0000_0000_0000_FFFF;
      TC_S32, TC_U32, TC_F32: return 64'h0000_0000_FFFF_FFFF;
      default:                return 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
  endfunction

  function automatic logic [6:0] lzc64(input logic [63:0] v);
    logic [6:0] n;
    n = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 7'(63 - i);
    end
    return n;
  endfunction

endpackage

[hw/rtl/numeric_type_converter.sv]
// Channel  | Handshake              | Payload
// ---------+------------------------+--------------------------------------------
// input    | start / busy (tied 0)  | in_value_bits[63:0], in_last_in
// result   | out_valid (1 cycle)    | out_result_bits[63:0], out_last_out,
//          |                        | out_unsupported
// config   | cfg_valid / cfg_ready  | cfg_index[1:0], cfg_data[2:0]
//
// A word is accepted on every cycle with start high; busy never rises.
// Each word passes through registered stages after acceptance: decode, normalize
// (leading-zero count and shift), align (rounding shifter), then round, clamp
// and pack into the output register. The 64-bit barrel shifters set the depth.
// Reset is synchronous and active low; it clears the valid bits and sets both
// type registers to float64. The receiver cannot stall, so nothing ever waits.
module numeric_type_converter
  import ntc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_value_bits,
  input  logic        in_last_in,
  output logic        out_valid,
  output logic [63:0] out_result_bits,
  output logic        out_last_out,
  output logic        out_unsupported,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_data
);

  type_code_t src_type_r, dst_type_r;
  logic       v1_r, v2_r, v3_r, out_valid_r;
  dec_t       s1_r, s1_nxt;
  norm_t      s2_r, s2_nxt;
  algn_t      s3_r, s3_nxt;
  logic [63:0] res_r, res_nxt;
  logic        last_r, unsup_r, unsup_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Type registers; writes to indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_type_r <= TC_F64;
      dst_type_r <= TC_F64;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_SRC_TYPE) src_type_r <= type_code_t'(cfg_data);
      if (cfg_index == REG_DST_TYPE) dst_type_r <= type_code_t'(cfg_data);
    end
  end

  // Stage 1: decode the source word into an integer value and a float form.
  // The float form is frac * 2^(exp-63), so frac[63] carries weight 2^exp.
  always_comb begin
    logic [33:0] mag;
    s1_nxt        = '0;
    s1_nxt.src    = src_type_r;
    s1_nxt.dst    = dst_type_r;
    s1_nxt.last   = in_last_in;
    s1_nxt.raw    = in_value_bits;
    case (src_type_r)
      TC_S8:   s1_nxt.ival = 34'(signed'(in_value_bits[7:0]));
      TC_U8:   s1_nxt.ival = {26'b0, in_value_bits[7:0]};
      TC_S16:  s1_nxt.ival = 34'(signed'(in_value_bits[15:0]));
      TC_U16:  s1_nxt.ival = {18'b0, in_value_bits[15:0]};
      TC_S32:  s1_nxt.ival = 34'(signed'(in_value_bits[31:0]));
      default: s1_nxt.ival = {2'b0, in_value_bits[31:0]};
    endcase
    mag = s1_nxt.ival[33] ? 34'(-s1_nxt.ival) : 34'(s1_nxt.ival);
    case (src_type_r)
      TC_F32: begin
        s1_nxt.sgn    = in_value_bits[31];
        s1_nxt.is_nan = (in_value_bits[30:23] == 8'hFF) && (in_value_bits[22:0] != '0);
        s1_nxt.is_inf = (in_value_bits[30:23] == 8'hFF) && (in_value_bits[22:0] == '0);
        if (in_value_bits[30:23] == 8'h00) begin
          s1_nxt.frac = {1'b0, in_value_bits[22:0], 40'b0};
          s1_nxt.exp  = -13'sd126;
        end else begin
          s1_nxt.frac = {1'b1, in_value_bits[22:0], 40'b0};
          s1_nxt.exp  = signed'({5'b0, in_value_bits[30:23]}) - 13'sd127;
        end
      end
      TC_F64: begin
        s1_nxt.sgn    = in_value_bits[63];
        s1_nxt.is_nan = (in_value_bits[62:52] == 11'h7FF) && (in_value_bits[51:0] != '0);
        s1_nxt.is_inf = (in_value_bits[62:52] == 11'h7FF) && (in_value_bits[51:0] == '0);
        if (in_value_bits[62:52] == 11'h000) begin
          s1_nxt.frac = {1'b0, in_value_bits[51:0], 11'b0};
          s1_nxt.exp  = -13'sd1022;
        end else begin
          s1_nxt.frac = {1'b1, in_value_bits[51:0], 11'b0};
          s1_nxt.exp  = signed'({2'b0, in_value_bits[62:52]}) - 13'sd1023;
        end
      end
      default: begin
        s1_nxt.sgn  = s1_nxt.ival[33];
        s1_nxt.frac = {mag[32:0], 31'b0};
        s1_nxt.exp  = 13'sd32;
      end
    endcase
  end

  // Stage 2: normalize so that the leading one sits in frac[63].
  always_comb begin
    logic [6:0] lz;
    lz             = lzc64(s1_r.frac);
    s2_nxt.src     = s1_r.src;
    s2_nxt.dst     = s1_r.dst;
    s2_nxt.last    = s1_r.last;
    s2_nxt.raw     = s1_r.raw;
    s2_nxt.ival    = s1_r.ival;
    s2_nxt.sgn     = s1_r.sgn;
    s2_nxt.is_nan  = s1_r.is_nan;
    s2_nxt.is_inf  = s1_r.is_inf;
    s2_nxt.is_zero = (s1_r.frac == '0);
    s2_nxt.frac    = s1_r.frac << lz[5:0];
    s2_nxt.exp     = s1_r.exp - signed'({6'b0, lz});
  end

  // Stage 3: align for single precision, pack double precision exactly,
  // and extract the integer part plus the half bit for integer results.
  always_comb begin
    logic signed [12:0] et;
    logic signed [12:0] sh;
    logic [63:0]        g;
    logic               sts;
    logic [6:0]         amt;
    s3_nxt.src     = s2_r.src;
    s3_nxt.dst     = s2_r.dst;
    s3_nxt.last    = s2_r.last;
    s3_nxt.raw     = s2_r.raw;
    s3_nxt.ival    = s2_r.ival;
    s3_nxt.sgn     = s2_r.sgn;
    s3_nxt.is_nan  = s2_r.is_nan;
    s3_nxt.is_inf  = s2_r.is_inf;
    s3_nxt.is_zero = s2_r.is_zero;

    et = s2_r.exp + 13'sd127;
    sh = 13'sd1 - et;
    if (et >= 13'sd1) begin
      g              = s2_r.frac;
      sts            = 1'b0;
      s3_nxt.sp_expb = et - 13'sd1;
    end else if (sh > 13'sd63) begin
      g              = '0;
      sts            = |s2_r.frac;
      s3_nxt.sp_expb = '0;
    end else begin
      g              = s2_r.frac >> sh[5:0];
      sts            = |(s2_r.frac & ((64'd1 << sh[5:0]) - 64'd1));
      s3_nxt.sp_expb = '0;
    end
    s3_nxt.sp_man    = g[63:40];
    s3_nxt.sp_guard  = g[39];
    s3_nxt.sp_sticky = (|g[38:0]) | sts;

    s3_nxt.dp_bits = {s2_r.sgn, 11'(s2_r.exp + 13'sd1023), s2_r.frac[62:11]};

    s3_nxt.int_huge = s2_r.is_inf || (!s2_r.is_zero && s2_r.exp > 13'sd33);
    amt             = 7'(13'sd62 - s2_r.exp);
    if (s2_r.is_zero || s2_r.exp < -13'sd1) s3_nxt.int_t = '0;
    else if (s2_r.exp > 13'sd33)            s3_nxt.int_t = '0;
    else                                    s3_nxt.int_t = 35'(s2_r.frac >> amt[5:0]);
  end

  // Stage 4: round (signed 32-bit integer results truncate instead), clamp and pack into the output register.
  always_comb begin
    logic [24:0]        m25;
    logic [39:0]        sum;
    logic [31:0]        sp;
    logic [63:0]        dp;
    logic [35:0]        m;
    logic signed [35:0] v;
    logic               ok;
    ok  = pair_ok(s3_r.dst, s3_r.src);
    m25 = {1'b0, s3_r.sp_man} +
          25'(s3_r.sp_guard & (s3_r.sp_sticky | s3_r.sp_man[0]));
    // The hidden bit of the mantissa carries into the exponent field.
    sum = {4'b0, s3_r.sp_expb, 23'b0} + 40'(m25);
    if (s3_r.sp_expb > 13'sd254 || sum >= 40'h0_7F80_0000)
      sp = {s3_r.sgn, 31'h7F80_0000};
    else
      sp = {s3_r.sgn, sum[30:0]};
    if (s3_r.is_nan)
      sp = {s3_r.raw[63], 31'h7FC0_0000 | {8'b0, s3_r.raw[51:29]}};
    else if (s3_r.is_inf)
      sp = {s3_r.sgn, 31'h7F80_0000};
    else if (s3_r.is_zero)
      sp = {s3_r.sgn, 31'b0};

    if (s3_r.is_nan)
      dp = {s3_r.raw[31], 63'h7FF8_0000_0000_0000 | {34'b0, s3_r.raw[22:0], 6'b0} << 23};
    else if (s3_r.is_inf)
      dp = {s3_r.sgn, 63'h7FF0_0000_0000_0000};
    else if (s3_r.is_zero)
      dp = {s3_r.sgn, 63'b0};
    else
      dp = s3_r.dp_bits;

    if (s3_r.int_huge)
      m = 36'h4_0000_0000;
    else
      m = {2'b0, s3_r.int_t[34:1]} +
          36'((s3_r.dst != TC_S32) & s3_r.int_t[0]);
    if (s3_r.src == TC_F32 || s3_r.src == TC_F64) begin
      if (s3_r.is_nan)
        v = (s3_r.dst == TC_S32 || s3_r.dst == TC_U32) ? 36'sd0 : int_hi(s3_r.dst);
      else
        v = s3_r.sgn ? -signed'(m) : signed'(m);
    end else begin
      v = {{2{s3_r.ival[33]}}, s3_r.ival};
    end
    if (v < int_lo(s3_r.dst)) v = int_lo(s3_r.dst);
    if (v > int_hi(s3_r.dst)) v = int_hi(s3_r.dst);

    unsup_nxt = !ok;
    if (!ok)                      res_nxt = '0;
    else if (s3_r.src == s3_r.dst) res_nxt = s3_r.raw & width_mask(s3_r.dst);
    else if (s3_r.dst == TC_F32)  res_nxt = {32'b0, sp};
    else if (s3_r.dst == TC_F64)  res_nxt = dp;
    else                          res_nxt = 64'(v) & width_mask(s3_r.dst);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= start && !busy;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_r    <= s1_nxt;
    s2_r    <= s2_nxt;
    s3_r    <= s3_nxt;
    res_r   <= res_nxt;
    last_r  <= s3_r.last;
    unsup_r <= unsup_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_result_bits = res_r;
  assign out_last_out    = last_r;
  assign out_unsupported = unsup_r;

  // Every accepted word comes out of the pipeline with out_valid set.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_valid)
    else $error("accepted word did not emerge after four cycles");

  // No result appears without a matching word accepted earlier into the decode stage.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(v1_r, 3))
    else $error("result without a matching accepted word");

  // An unsupported pair always reports a zero word.
  a_unsup_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_unsupported) |-> (out_result_bits == 64'd0))
    else $error("unsupported pair returned nonzero data");

endmodule
